FILE: rtl/heightmap_cross_smoothing_pass_defines.svh
// Assertion helpers used by the RTL top module.
`ifndef HEIGHTMAP_CROSS_SMOOTHING_PASS_DEFINES_SVH
`define HEIGHTMAP_CROSS_SMOOTHING_PASS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCS_ASSERT_NOW(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define HCS_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

FILE: rtl/hcs_pkg.sv
package hcs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + 3;
  localparam int MAP_W_BITS = 11;
  localparam int MAP_H_BITS = 13;
  localparam int ROW_BITS   = 12;
  localparam int MAX_ROWS   = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam int RESET_MAP_WIDTH  = 256;
  localparam int RESET_MAP_HEIGHT = 256;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t height_out;
    logic    last_of_run;
    logic    frame_end;
  } out_item_t;

  // Up to two results per accepted sample, a goes out before b.
  typedef struct packed {
    logic [1:0] n;
    out_item_t  a;
    out_item_t  b;
  } push_t;

endpackage

FILE: rtl/hcs_stream_if.sv
interface hcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/hcs_line_buf.sv
module hcs_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  hcs_pkg::sample_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output hcs_pkg::sample_t         rdata
);
  import hcs_pkg::*;

  sample_t mem [DEPTH];
  sample_t rd_raw_r;
  sample_t byp_r;
  logic    hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_raw_r <= mem[raddr];
      byp_r    <= wdata;
    end
  end

  // read of the address written in the same cycle returns the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (re) begin
      hit_r <= we && (waddr == raddr);
    end
  end

  assign rdata = hit_r ? byp_r : rd_raw_r;

endmodule

FILE: rtl/hcs_out_fifo.sv
module hcs_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  hcs_pkg::push_t     push,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output hcs_pkg::out_item_t out_item
);
  import hcs_pkg::*;

  out_item_t        slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop        = (cnt_r != '0) && out_ready;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slot_r[wr_ptr_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      slot_r[wr_ptr_r + PTR_W'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // room for the worst case of two results from one sample
  assign can_push  = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = slot_r[rd_ptr_r];

endmodule

FILE: rtl/heightmap_cross_smoothing_pass.sv
// Streaming four-neighbor smoothing pass over a raster-order heightmap. One sample is
// accepted per clock while the output queue has room; interior sample (x, y-1) is
// emitted as (left + right + up + down + 4*center + 4) >> 3 while sample (x, y) arrives,
// border rows and columns pass through, the first row gives no result and the final row
// gives its own sample as a second result, so during the final row the single output port
// limits the input rate. Results enter a four-entry output queue in the cycle of
// acceptance and are available in the next cycle; in_ch.ready is high while at least two
// entries are free. Two MAX_WIDTH-deep line buffers (one read port each, registered read
// data) hold the two rows above; their contents are undefined until written and no
// clearing pass runs after reset. Writing map_width or map_height restarts the frame at
// column 0, row 0 and must only happen while the block is idle.
`include "heightmap_cross_smoothing_pass_defines.svh"
module heightmap_cross_smoothing_pass #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hcs_stream_if.sink                    in_ch,
  hcs_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [hcs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hcs_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (MAX_WIDTH < RESET_MAP_WIDTH) ? MAX_WIDTH : RESET_MAP_WIDTH;

  logic [XW-1:0]         x_r, x_nxt;
  logic [ROW_BITS-1:0]   y_r, y_nxt;
  logic [WW-1:0]         eff_w_r, eff_w_nxt;
  logic [MAP_H_BITS-1:0] eff_h_r, eff_h_nxt;
  logic [MAP_W_BITS-1:0] wr_w;
  logic [MAP_H_BITS-1:0] wr_h;
  logic                  cfg_hit;

  sample_t lft_r, cen_r, row0_r;
  sample_t a_rd, b_rd, s, smooth;
  logic [XW-1:0]    a_raddr, b_raddr;
  logic [SUM_W-1:0] sum;

  logic  in_fire, first_col, last_col, last_row, have_prev, interior, can_push;
  push_t push;

  assign s       = in_ch.payload;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = can_push;

  // configuration: clamp to the supported range when written
  assign wr_w    = cfg_data[MAP_W_BITS-1:0];
  assign wr_h    = cfg_data[MAP_H_BITS-1:0];
  assign cfg_hit = cfg_we && ((cfg_idx == REG_MAP_WIDTH) || (cfg_idx == REG_MAP_HEIGHT));

  always_comb begin
    if (wr_w == '0) begin
      eff_w_nxt = WW'(1);
    end else if (32'(wr_w) > 32'(MAX_WIDTH)) begin
      eff_w_nxt = WW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = WW'(wr_w);
    end
    if (wr_h == '0) begin
      eff_h_nxt = MAP_H_BITS'(1);
    end else if (32'(wr_h) > 32'(MAX_ROWS)) begin
      eff_h_nxt = MAP_H_BITS'(MAX_ROWS);
    end else begin
      eff_h_nxt = wr_h;
    end
  end

  // position in the frame
  assign first_col = x_r == '0;
  assign last_col  = (WW'(x_r) + WW'(1)) == eff_w_r;
  assign last_row  = ({1'b0, y_r} + MAP_H_BITS'(1)) == eff_h_r;
  assign have_prev = y_r != '0;
  assign interior  = (y_r >= ROW_BITS'(2)) && !first_col && !last_col;

  assign x_nxt = last_col ? '0 : x_r + XW'(1);
  assign y_nxt = last_col ? (last_row ? '0 : y_r + ROW_BITS'(1)) : y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r     <= '0;
      y_r     <= '0;
      eff_w_r <= WW'(RESET_W);
      eff_h_r <= MAP_H_BITS'(RESET_MAP_HEIGHT);
    end else if (cfg_hit) begin
      x_r <= '0;
      y_r <= '0;
      if (cfg_idx == REG_MAP_WIDTH) begin
        eff_w_r <= eff_w_nxt;
      end else begin
        eff_h_r <= eff_h_nxt;
      end
    end else if (in_fire) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // Window on the row above: lft_r/cen_r are registers, the right neighbor and the
  // sample two rows up come straight from the buffers' read registers, fetched one
  // request ahead. At a row end the next row starts over at column 0.
  assign a_raddr = last_col ? XW'(1) : x_r + XW'(2);
  assign b_raddr = last_col ? '0 : x_r + XW'(1);

  hcs_line_buf #(.DEPTH(MAX_WIDTH)) u_row_above (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_fire),
    .waddr (x_r),
    .wdata (s),
    .re    (in_fire),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  hcs_line_buf #(.DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_fire),
    .waddr (x_r),
    .wdata (cen_r),
    .re    (in_fire),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (first_col) begin
        row0_r <= s;
      end
      if (last_col) begin
        cen_r <= first_col ? s : row0_r;
      end else begin
        lft_r <= cen_r;
        cen_r <= a_rd;
      end
    end
  end

  assign sum = SUM_W'(lft_r) + SUM_W'(a_rd) + SUM_W'(b_rd) + SUM_W'(s)
             + (SUM_W'(cen_r) << 2) + SUM_W'(4);
  assign smooth = interior ? sum[SUM_W-1:3] : cen_r;

  always_comb begin
    push = '0;
    if (in_fire) begin
      if (have_prev) begin
        push.a.height_out  = smooth;
        push.a.last_of_run = !last_row;
        push.a.frame_end   = 1'b0;
        if (last_row) begin
          push.b.height_out  = s;
          push.b.last_of_run = 1'b1;
          push.b.frame_end   = last_col;
          push.n             = 2'd2;
        end else begin
          push.n = 2'd1;
        end
      end else if (last_row) begin
        // single-row frame
        push.a.height_out  = s;
        push.a.last_of_run = 1'b1;
        push.a.frame_end   = last_col;
        push.n             = 2'd1;
      end
    end
  end

  hcs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload)
  );

  `HCS_ASSERT_NOW(a_col_in_range, clk, rst_n, in_fire, (WW'(x_r) < eff_w_r), "column past width")
  `HCS_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_fire && last_col && last_row, (x_r == '0) && (y_r == '0), "frame did not wrap")
  `HCS_ASSERT_NOW(a_end_is_last, clk, rst_n, out_ch.valid && out_ch.payload.frame_end, out_ch.payload.last_of_run, "frame end not last of run")

endmodule

FILE: tb/tb_heightmap_cross_smoothing_pass.sv
`timescale 1ns / 100ps

module tb_heightmap_cross_smoothing_pass;
  import hcs_pkg::*;

  localparam int MAP_MAX_W     = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 400;
  localparam int TALL_ITEMS    = 64;
  localparam int MAX_BURST     = 300;

  // indexes past the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum int {DATA_RANDOM, DATA_EXTREME, DATA_RAMP} data_mode_e;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hcs_stream_if #(.payload_t(sample_t))   in_if ();
  hcs_stream_if #(.payload_t(out_item_t)) out_if ();

  heightmap_cross_smoothing_pass #(.MAX_WIDTH(MAP_MAX_W)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  sample_t         above_row     [MAP_MAX_W] = '{default: '0};
  sample_t         two_above_row [MAP_MAX_W] = '{default: '0};
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;
  logic [10:0]     width_reg  = 11'(RESET_MAP_WIDTH);
  logic [12:0]     height_reg = 13'(RESET_MAP_HEIGHT);

  out_item_t   heights_due[$];
  int unsigned fail_count = 0;
  bit          no_gaps = 1'b0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAP_MAX_W) return MAP_MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return 32'(height_reg);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t pick_height(input data_mode_e mode, input int unsigned idx);
    case (mode)
      DATA_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      DATA_RAMP:    return sample_t'(idx * 37 + $urandom_range(0, 15));
      default:      return sample_t'($urandom);
    endcase
  endfunction

  // Row y-1 comes out while row y arrives; the final row also gives its own sample.
  task automatic predict_smoothed(input sample_t s);
    int unsigned w, h, x, y, acc;
    out_item_t   item;
    w = eff_width();
    h = eff_height();
    x = col_pos;
    y = row_pos;
    if (y >= 1) begin
      acc = 32'(above_row[x]);
      if (y >= 2 && x >= 1 && x + 1 < w)
        acc = (32'(two_above_row[x-1]) + 32'(above_row[x+1]) + 32'(two_above_row[x])
               + 32'(s) + 4 * 32'(above_row[x]) + 4) >> 3;
      item.height_out  = sample_t'(acc);
      item.last_of_run = (y + 1 != h);
      item.frame_end   = 1'b0;
      heights_due = {heights_due, item};
    end
    if (y + 1 == h) begin
      item.height_out  = s;
      item.last_of_run = 1'b1;
      item.frame_end   = (x + 1 == w);
      heights_due = {heights_due, item};
    end
    two_above_row[x] = above_row[x];
    above_row[x]     = s;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR %0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic send_height(input sample_t s);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_smoothed(s);
  endtask

  // first-row samples give no result, so let the pipeline settle after the queue drains
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAP_WIDTH: begin
        width_reg = data[10:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_MAP_HEIGHT: begin
        height_reg = data[12:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      default: ;
    endcase
  endtask

  // result side: check each accepted result, then drive ready for the next edge
  int stall_left = 0;
  always @(posedge clk) begin : result_port
    out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (heights_due.size() == 0) begin
          report_mismatch("result with nothing expected",
                          32'(out_if.payload.height_out), 0);
        end else begin
          want = heights_due.pop_front();
          if (out_if.payload.height_out !== want.height_out)
            report_mismatch("height_out", 32'(out_if.payload.height_out),
                            32'(want.height_out));
          if (out_if.payload.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_if.payload.last_of_run),
                            32'(want.last_of_run));
          if (out_if.payload.frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(out_if.payload.frame_end),
                            32'(want.frame_end));
        end
      end
      if (no_gaps) begin
        stall_left = 0;
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = gap_len();
        out_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // registers still at reset values: 256 x 256
  task automatic test_reset_geometry();
    for (int i = 0; i < 300; i++) send_height(pick_height(DATA_RANDOM, i));
  endtask

  task automatic test_directed_corners();
    write_reg(REG_MAP_WIDTH, 13'd3);
    write_reg(REG_MAP_HEIGHT, 13'd3);
    // full-scale everywhere: the weighted sum must not wrap
    for (int i = 0; i < 9; i++) send_height(16'hFFFF);
    // lone full-scale center on zeros: rounds half up
    for (int i = 0; i < 9; i++) send_height((i == 4) ? 16'hFFFF : 16'h0000);
    // single-row frame passes straight through
    write_reg(REG_MAP_WIDTH, 13'd4);
    write_reg(REG_MAP_HEIGHT, 13'd1);
    for (int i = 0; i < 4; i++) send_height(i[0] ? 16'hFFFF : 16'h0000);
    // zero width and height act as 1 x 1
    write_reg(REG_MAP_WIDTH, 13'd0);
    write_reg(REG_MAP_HEIGHT, 13'd0);
    send_height(16'h8001);
  endtask

  task automatic test_register_restart();
    write_reg(REG_MAP_WIDTH, 13'd5);
    write_reg(REG_MAP_HEIGHT, 13'd4);
    for (int i = 0; i < 7; i++) send_height(pick_height(DATA_RANDOM, i));
    // unknown index: frame position must be kept
    write_reg(REG_UNUSED_3, CFG_DATA_W'($urandom));
    for (int i = 0; i < 6; i++) send_height(pick_height(DATA_RANDOM, i));
    // known index mid-frame: restart at row 0
    write_reg(REG_MAP_HEIGHT, 13'd4);
    for (int i = 0; i < 20; i++) send_height(pick_height(DATA_RAMP, i));
  endtask

  // width 1 with high data bits set, height written past the row limit
  task automatic test_tall_column();
    write_reg(REG_MAP_WIDTH, 13'h1801);
    write_reg(REG_MAP_HEIGHT, 13'h1FFF);
    for (int i = 0; i < TALL_ITEMS; i++) send_height(pick_height(DATA_RANDOM, i));
  endtask

  // one full row at the widest setting, then the start of the final row
  task automatic test_wide_map();
    write_reg(REG_MAP_WIDTH, 13'(MAP_MAX_W));
    write_reg(REG_MAP_HEIGHT, 13'd2);
    for (int i = 0; i < MAP_MAX_W + 8; i++) send_height(pick_height(DATA_RANDOM, i));
  endtask

  task automatic test_random_frames();
    int unsigned           sent, count, frame, w_eff, h_eff, r;
    logic [10:0]           w_val;
    logic [12:0]           h_val;
    logic [CFG_DATA_W-1:0] cfg_word;
    data_mode_e            mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      w_val = 11'($urandom_range(1, 8));
      else if (r < 88) w_val = 11'($urandom_range(9, 40));
      else if (r < 94) w_val = '0;
      else             w_val = 11'($urandom_range(1025, 2047));
      r = $urandom_range(0, 99);
      if (r < 75)      h_val = 13'($urandom_range(1, 6));
      else if (r < 85) h_val = '0;
      else if (r < 97) h_val = 13'($urandom_range(7, 20));
      else             h_val = 13'($urandom_range(4097, 8191));
      if (w_val > 40) h_val = 13'($urandom_range(1, 2));
      cfg_word = CFG_DATA_W'($urandom);
      cfg_word[10:0] = w_val;
      write_reg(REG_MAP_WIDTH, cfg_word);
      write_reg(REG_MAP_HEIGHT, h_val);
      w_eff = eff_width();
      h_eff = eff_height();
      frame = w_eff * h_eff;
      if ($urandom_range(0, 99) < 60) count = frame * $urandom_range(1, 3);
      else                            count = $urandom_range(1, frame);
      if (count > MAX_BURST) count = $urandom_range(1, MAX_BURST);
      mode    = data_mode_e'($urandom_range(0, 2));
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < count; i++) send_height(pick_height(mode, i));
      sent += count;
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_DATA_W'($urandom));
        count = $urandom_range(1, 5);
        for (int i = 0; i < count; i++) send_height(pick_height(mode, i));
        sent += count;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_directed_corners();
    test_register_restart();
    test_tall_column();
    test_wide_map();
    test_random_frames();

    wait_idle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
